@@ rtl/sjsc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sjsc_pkg: shared types, constants and helpers
// sequencer states, operation codes, fixed-point constants and saturating
// arithmetic used by the s-curve profile generator
// ----------------------------------------------------------------------------
package sjsc_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_LOAD,
    ST_DIV_RUN,
    ST_SETUP,
    ST_MUL,
    ST_CORDIC,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    DIV_HALF,
    DIV_VC,
    DIV_INV,
    DIV_PHASE
  } div_op_t;

  typedef enum logic [3:0] {
    MUL_CRUISE,
    MUL_ANGLE,
    MUL_FSQ,
    MUL_COS,
    MUL_SCALE,
    MUL_CORE,
    MUL_SIN,
    MUL_VEL,
    MUL_APK,
    MUL_ACC,
    MUL_APK_INV,
    MUL_TWO_PI,
    MUL_JERK
  } mul_op_t;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_TOTAL_TIME = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PEAK_RATIO = 2'd1;

  localparam logic [31:0] TOTAL_TIME_RESET = 32'd16777216;
  localparam logic [16:0] PEAK_RATIO_RESET = 17'd49152;
  localparam logic [16:0] PEAK_RATIO_MIN   = 17'd32769;

  localparam logic signed [63:0] ONE_Q32     = 64'sh0000_0001_0000_0000;
  localparam logic signed [63:0] TWO_PI_Q32  = 64'sd26986075409;
  localparam logic signed [63:0] INV_2PI_Q32 = 64'sd683565276;
  localparam logic signed [63:0] INV_4PI2_Q32 = 64'sd108792793;
  localparam logic [63:0]        PI_Q62      = 64'hC90F_DAA2_2168_C235;
  localparam logic [63:0]        GAIN_Q60    = 64'h09B7_4EDA_8000_0000;
  localparam logic signed [63:0] S64_MAX     = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN     = 64'sh8000_0000_0000_0000;

  // arctangent of 2^-i in q4.60, from the alternating series in q0.62
  function automatic logic [63:0] atan_entry(input int i);
    logic [63:0] acc;
    logic [63:0] term;
    int          e;
    acc = 64'd0;
    if (i == 0) begin
      acc = (PI_Q62 + 64'd8) >> 4;
    end else begin
      for (int k = 0; k < 32; k++) begin
        e = 62 - i * (2 * k + 1);
        if (e >= 0) begin
          term = (64'd1 << e) / 64'(2 * k + 1);
          if (k % 2 == 1) acc = acc - term;
          else            acc = acc + term;
        end
      end
      acc = (acc + 64'd2) >> 2;
    end
    return acc;
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] x);
    return x[63] ? 64'(-x) : 64'(x);
  endfunction

  function automatic logic signed [63:0] from_mag(input logic [63:0] m, input logic neg);
    logic signed [63:0] r;
    if (neg) begin
      if (m[63]) r = S64_MIN;
      else       r = -$signed(m);
    end else begin
      if (m[63]) r = S64_MAX;
      else       r = $signed(m);
    end
    return r;
  endfunction

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return $signed(s[63:0]);
  endfunction

  function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return $signed(s[63:0]);
  endfunction

endpackage
`default_nettype wire

@@ rtl/sine_jerk_scurve_profile.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sine_jerk_scurve_profile: s-curve motion profile with sinusoidal jerk
// normalized point-to-point profile: position, velocity, acceleration and
// jerk in signed q32.32 for one unsigned q8.24 sample time per word
// ----------------------------------------------------------------------------
// A word on the input channel is one sample time; a sample time of zero
// restarts the move and latches the accel end time, cruise end time, cruise
// velocity and reciprocal accel time from total_time and peak_velocity_ratio.
// Each input word gives exactly one output word. The block handles one word
// at a time: in_stall is high from acceptance until the result is placed in
// the output register, which then waits for the consumer while a new word can
// already be taken. Divisions, products and rotations run through three shared
// units under one sequencer: a radix-2 restoring divider with a load state, a
// 32x32 multiplier accumulating four partial products per 64x64 product and a
// CORDIC rotator (one step per cycle). A cruise sample takes a setup step and
// one product; an accelerate or decelerate sample takes setup, the phase
// division, the angle product, the CORDIC rotation and the product chain up
// to jerk; a restart sample first runs the three divisions.
// ----------------------------------------------------------------------------
module sine_jerk_scurve_profile #(
  parameter int CORDIC_ITERATIONS = 24
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // configuration
  input  wire logic                              cfg_wr_en,
  input  wire logic [sjsc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [31:0]                       cfg_data,
  // input channel
  input  wire logic                              in_valid,
  output      logic                              in_stall,
  input  wire logic [31:0]                       sample_time,
  // output channel
  output      logic                              out_valid,
  input  wire logic                              out_stall,
  output      logic signed [63:0]                position,
  output      logic signed [63:0]                velocity,
  output      logic signed [63:0]                acceleration,
  output      logic signed [63:0]                jerk_value
);

  localparam int CNT_W = $clog2(CORDIC_ITERATIONS + 1);
  localparam int SH_W  = $clog2(CORDIC_ITERATIONS);

  // configuration registers
  logic [31:0] total_time;
  logic [16:0] peak_velocity_ratio;

  // sequencer
  sjsc_pkg::state_t  state, state_next;
  sjsc_pkg::div_op_t div_op;
  sjsc_pkg::mul_op_t mul_op;

  // latched move quantities
  logic [31:0]        accel_end_time;
  logic [31:0]        cruise_end_time;
  logic signed [63:0] cruise_velocity;
  logic signed [63:0] inverse_accel_time;

  // per-sample working registers
  logic [31:0]        t_r;
  logic               decel;
  logic               u_neg;
  logic [31:0]        u_mag;
  logic signed [63:0] f_r;
  logic signed [63:0] c_r, s_r;
  logic signed [63:0] tmp_r, core_r, vel_r, apk_r, acc_r, jerk_r;

  // divider
  logic [31:0] div_rem;
  logic [63:0] div_quo;
  logic [31:0] div_den;
  logic [5:0]  div_cnt;

  // multiplier
  logic [2:0]   mul_cnt;
  logic [63:0]  prod_r;
  logic [1:0]   prod_sh;
  logic [127:0] mul_acc;

  // cordic
  logic signed [63:0] x_r, y_r, z_r;
  logic [CNT_W-1:0]   cor_cnt;
  logic [63:0]        atan_tab [CORDIC_ITERATIONS];

  for (genvar g = 0; g < CORDIC_ITERATIONS; g++) begin : g_atan
    assign atan_tab[g] = sjsc_pkg::atan_entry(g);
  end

  // --------------------------------------------------------------------------
  // derived values
  // --------------------------------------------------------------------------
  logic [31:0] tt;
  logic [16:0] pv;
  logic        in_cruise;
  logic        past_accel;
  logic [32:0] u_diff;
  logic [63:0] cruise_d;

  // zero total time counts as one lsb, ratio at or below one half is raised
  assign tt = (total_time == 32'd0) ? 32'd1 : total_time;
  assign pv = (peak_velocity_ratio < sjsc_pkg::PEAK_RATIO_MIN) ?
              sjsc_pkg::PEAK_RATIO_MIN : peak_velocity_ratio;

  assign past_accel = t_r > accel_end_time;
  assign in_cruise  = past_accel && (t_r <= cruise_end_time);
  assign u_diff     = {1'b0, tt} - {1'b0, t_r};
  assign cruise_d   = 64'({t_r, 1'b0}) - 64'(accel_end_time);

  // divider step
  logic [32:0] div_trial;
  logic        div_ge;
  logic [31:0] div_rem_next;
  logic [63:0] div_quo_next;

  assign div_trial    = {div_rem, div_quo[63]};
  assign div_ge       = div_trial >= {1'b0, div_den};
  assign div_rem_next = div_ge ? 32'(div_trial - {1'b0, div_den}) : div_trial[31:0];
  assign div_quo_next = {div_quo[62:0], div_ge};

  // angle fold to the nearest quadrant
  logic [31:0] ph_p, ph_off, ph_r;
  logic [1:0]  quad;
  logic        ph_neg;
  logic [32:0] ph_mag;

  assign ph_p   = f_r[31:0];
  assign ph_off = ph_p + 32'h2000_0000;
  assign quad   = ph_off[31:30];
  assign ph_r   = ph_p - {quad, 30'd0};
  assign ph_neg = ph_r[31];
  assign ph_mag = ph_neg ? (33'h1_0000_0000 - {1'b0, ph_r}) : {1'b0, ph_r};

  // multiplier operand selection
  logic signed [63:0] op_a, op_b;
  logic [63:0]        mag_a, mag_b;
  logic               mul_neg;
  logic [63:0]        pp;
  logic [127:0]       prod_ext;
  logic [127:0]       mul_sum;
  logic [63:0]        mul_m;
  logic signed [63:0] mul_res;
  logic [63:0]        angle_th;

  always_comb begin
    op_a = cruise_velocity;
    op_b = 64'sd0;
    case (mul_op)
      sjsc_pkg::MUL_CRUISE:  begin op_a = cruise_velocity;  op_b = $signed(cruise_d << 7); end
      sjsc_pkg::MUL_ANGLE:   begin op_a = 64'sd0;           op_b = 64'sd0; end
      sjsc_pkg::MUL_FSQ:     begin op_a = f_r;              op_b = f_r; end
      sjsc_pkg::MUL_COS:     begin
        op_a = c_r - sjsc_pkg::ONE_Q32;
        op_b = sjsc_pkg::INV_4PI2_Q32;
      end
      sjsc_pkg::MUL_SCALE:   begin
        op_a = cruise_velocity;
        op_b = $signed({24'd0, accel_end_time, 8'd0});
      end
      sjsc_pkg::MUL_CORE:    begin op_a = core_r;           op_b = tmp_r; end
      sjsc_pkg::MUL_SIN:     begin op_a = s_r;              op_b = sjsc_pkg::INV_2PI_Q32; end
      sjsc_pkg::MUL_VEL:     begin
        op_a = cruise_velocity;
        op_b = sjsc_pkg::sat_sub(f_r, tmp_r);
      end
      sjsc_pkg::MUL_APK:     begin op_a = cruise_velocity;  op_b = inverse_accel_time; end
      sjsc_pkg::MUL_ACC:     begin op_a = apk_r;            op_b = sjsc_pkg::ONE_Q32 - c_r; end
      sjsc_pkg::MUL_APK_INV: begin op_a = apk_r;            op_b = inverse_accel_time; end
      sjsc_pkg::MUL_TWO_PI:  begin op_a = sjsc_pkg::TWO_PI_Q32; op_b = tmp_r; end
      sjsc_pkg::MUL_JERK:    begin op_a = tmp_r;            op_b = s_r; end
      default:               begin op_a = 64'sd0;           op_b = 64'sd0; end
    endcase
  end

  // the angle product is unsigned: folded phase times pi
  always_comb begin
    if (mul_op == sjsc_pkg::MUL_ANGLE) begin
      mag_a = {31'd0, ph_mag};
      mag_b = sjsc_pkg::PI_Q62;
    end else begin
      mag_a = sjsc_pkg::mag64(op_a);
      mag_b = sjsc_pkg::mag64(op_b);
    end
  end

  assign mul_neg = op_a[63] ^ op_b[63];
  assign pp = (mul_cnt[0] ? mag_a[63:32] : mag_a[31:0]) *
              (mul_cnt[1] ? mag_b[63:32] : mag_b[31:0]);

  always_comb begin
    case (prod_sh)
      2'd0:    prod_ext = {64'd0, prod_r};
      2'd1:    prod_ext = {32'd0, prod_r, 32'd0};
      default: prod_ext = {prod_r, 64'd0};
    endcase
  end

  assign mul_sum  = mul_acc + prod_ext;
  assign mul_m    = (mul_sum[127:95] != 33'd0) ? {64{1'b1}} : mul_sum[95:32];
  assign mul_res  = sjsc_pkg::from_mag(mul_m, mul_neg);
  assign angle_th = mul_sum[96:33];

  // cordic step and output conversion
  logic [SH_W-1:0]    cor_sh;
  logic signed [63:0] cor_dx, cor_dy;
  logic [63:0]        x_rnd, y_rnd;
  logic signed [63:0] c0, s0;

  assign cor_sh = cor_cnt[SH_W-1:0];
  assign cor_dx = y_r >>> cor_sh;
  assign cor_dy = x_r >>> cor_sh;
  assign x_rnd  = x_r + 64'd134217728;
  assign y_rnd  = y_r + 64'd134217728;
  assign c0     = $signed({{28{x_rnd[63]}}, x_rnd[63:28]});
  assign s0     = $signed({{28{y_rnd[63]}}, y_rnd[63:28]});

  logic mul_last, div_last, cor_last, out_load;
  assign mul_last = mul_cnt == 3'd4;
  assign div_last = div_cnt == 6'd63;
  assign cor_last = cor_cnt == CNT_W'(CORDIC_ITERATIONS);
  assign out_load = (state == sjsc_pkg::ST_FINISH) && (!out_valid || !out_stall);

  // --------------------------------------------------------------------------
  // next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      sjsc_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = (sample_time == 32'd0) ? sjsc_pkg::ST_DIV_LOAD : sjsc_pkg::ST_SETUP;
        end
      end
      sjsc_pkg::ST_DIV_LOAD: state_next = sjsc_pkg::ST_DIV_RUN;
      sjsc_pkg::ST_DIV_RUN: begin
        if (div_last) begin
          case (div_op)
            sjsc_pkg::DIV_HALF,
            sjsc_pkg::DIV_VC:  state_next = sjsc_pkg::ST_DIV_LOAD;
            sjsc_pkg::DIV_INV: state_next = sjsc_pkg::ST_SETUP;
            default:           state_next = sjsc_pkg::ST_MUL;
          endcase
        end
      end
      sjsc_pkg::ST_SETUP: begin
        state_next = in_cruise ? sjsc_pkg::ST_MUL : sjsc_pkg::ST_DIV_LOAD;
      end
      sjsc_pkg::ST_MUL: begin
        if (mul_last) begin
          case (mul_op)
            sjsc_pkg::MUL_ANGLE:  state_next = sjsc_pkg::ST_CORDIC;
            sjsc_pkg::MUL_CRUISE,
            sjsc_pkg::MUL_JERK:   state_next = sjsc_pkg::ST_FINISH;
            default:              state_next = sjsc_pkg::ST_MUL;
          endcase
        end
      end
      sjsc_pkg::ST_CORDIC: begin
        if (cor_last) state_next = sjsc_pkg::ST_MUL;
      end
      sjsc_pkg::ST_FINISH: begin
        if (!out_valid || !out_stall) state_next = sjsc_pkg::ST_IDLE;
      end
      default: state_next = sjsc_pkg::ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // handshake outputs
  // --------------------------------------------------------------------------
  always_comb begin
    in_stall = state != sjsc_pkg::ST_IDLE;
  end

  // --------------------------------------------------------------------------
  // control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= sjsc_pkg::ST_IDLE;
      total_time          <= sjsc_pkg::TOTAL_TIME_RESET;
      peak_velocity_ratio <= sjsc_pkg::PEAK_RATIO_RESET;
      accel_end_time      <= 32'd0;
      cruise_end_time     <= 32'd0;
      cruise_velocity     <= 64'sd0;
      inverse_accel_time  <= 64'sd0;
      out_valid           <= 1'b0;
      div_op              <= sjsc_pkg::DIV_HALF;
      mul_op              <= sjsc_pkg::MUL_CRUISE;
    end else begin
      state <= state_next;

      if (cfg_wr_en) begin
        case (cfg_index)
          sjsc_pkg::REG_TOTAL_TIME: total_time          <= cfg_data;
          sjsc_pkg::REG_PEAK_RATIO: peak_velocity_ratio <= cfg_data[16:0];
          default: ;
        endcase
      end

      if (out_load)                   out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;

      case (state)
        sjsc_pkg::ST_IDLE: begin
          div_op <= sjsc_pkg::DIV_HALF;
        end
        sjsc_pkg::ST_DIV_RUN: begin
          if (div_last) begin
            case (div_op)
              sjsc_pkg::DIV_HALF: begin
                accel_end_time  <= tt - div_quo_next[31:0];
                cruise_end_time <= div_quo_next[31:0];
                div_op          <= sjsc_pkg::DIV_VC;
              end
              sjsc_pkg::DIV_VC: begin
                cruise_velocity <= $signed(div_quo_next);
                div_op          <= sjsc_pkg::DIV_INV;
              end
              sjsc_pkg::DIV_INV: begin
                inverse_accel_time <= $signed(div_quo_next);
              end
              default: mul_op <= sjsc_pkg::MUL_ANGLE;
            endcase
          end
        end
        sjsc_pkg::ST_SETUP: begin
          if (in_cruise) mul_op <= sjsc_pkg::MUL_CRUISE;
          else           div_op <= sjsc_pkg::DIV_PHASE;
        end
        sjsc_pkg::ST_CORDIC: begin
          if (cor_last) mul_op <= sjsc_pkg::MUL_FSQ;
        end
        sjsc_pkg::ST_MUL: begin
          // walk the product chain in order
          if (mul_last) begin
            case (mul_op)
              sjsc_pkg::MUL_FSQ:     mul_op <= sjsc_pkg::MUL_COS;
              sjsc_pkg::MUL_COS:     mul_op <= sjsc_pkg::MUL_SCALE;
              sjsc_pkg::MUL_SCALE:   mul_op <= sjsc_pkg::MUL_CORE;
              sjsc_pkg::MUL_CORE:    mul_op <= sjsc_pkg::MUL_SIN;
              sjsc_pkg::MUL_SIN:     mul_op <= sjsc_pkg::MUL_VEL;
              sjsc_pkg::MUL_VEL:     mul_op <= sjsc_pkg::MUL_APK;
              sjsc_pkg::MUL_APK:     mul_op <= sjsc_pkg::MUL_ACC;
              sjsc_pkg::MUL_ACC:     mul_op <= sjsc_pkg::MUL_APK_INV;
              sjsc_pkg::MUL_APK_INV: mul_op <= sjsc_pkg::MUL_TWO_PI;
              sjsc_pkg::MUL_TWO_PI:  mul_op <= sjsc_pkg::MUL_JERK;
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    div_cnt <= (state == sjsc_pkg::ST_DIV_LOAD) ? 6'd0 : div_cnt + 6'd1;
    mul_cnt <= (state == sjsc_pkg::ST_MUL && !mul_last) ? mul_cnt + 3'd1 : 3'd0;
    cor_cnt <= (state == sjsc_pkg::ST_CORDIC) ? cor_cnt + CNT_W'(1) : CNT_W'(0);

    case (state)
      sjsc_pkg::ST_IDLE: begin
        t_r <= sample_time;
      end

      sjsc_pkg::ST_DIV_LOAD: begin
        div_rem <= 32'd0;
        case (div_op)
          sjsc_pkg::DIV_HALF: begin
            div_quo <= {17'd0, tt, 15'd0};
            div_den <= {15'd0, pv};
          end
          sjsc_pkg::DIV_VC: begin
            div_quo <= {6'd0, pv, 41'd0};
            div_den <= tt;
          end
          sjsc_pkg::DIV_INV: begin
            div_quo <= 64'h0100_0000_0000_0000;
            div_den <= accel_end_time;
          end
          default: begin
            div_quo <= {u_mag, 32'd0};
            div_den <= accel_end_time;
          end
        endcase
      end

      sjsc_pkg::ST_DIV_RUN: begin
        div_rem <= div_rem_next;
        div_quo <= div_quo_next;
        // no move latched: phase is zero
        if (div_last && div_op == sjsc_pkg::DIV_PHASE) begin
          f_r <= (accel_end_time == 32'd0) ? 64'sd0 :
                 sjsc_pkg::from_mag(div_quo_next, u_neg);
        end
      end

      sjsc_pkg::ST_SETUP: begin
        decel <= past_accel && !in_cruise;
        if (past_accel) begin
          u_neg <= u_diff[32];
          u_mag <= u_diff[32] ? 32'(-u_diff) : u_diff[31:0];
        end else begin
          u_neg <= 1'b0;
          u_mag <= t_r;
        end
      end

      sjsc_pkg::ST_MUL: begin
        if (mul_cnt != 3'd4) begin
          prod_r  <= pp;
          prod_sh <= 2'(mul_cnt[0]) + 2'(mul_cnt[1]);
        end
        mul_acc <= (mul_cnt == 3'd0) ? 128'd0 : mul_sum;
        if (mul_last) begin
          case (mul_op)
            sjsc_pkg::MUL_CRUISE: begin
              core_r <= mul_res;
              vel_r  <= cruise_velocity;
              acc_r  <= 64'sd0;
              jerk_r <= 64'sd0;
            end
            sjsc_pkg::MUL_ANGLE: begin
              x_r <= $signed(sjsc_pkg::GAIN_Q60);
              y_r <= 64'sd0;
              z_r <= ph_neg ? $signed(64'(-angle_th)) : $signed(angle_th);
            end
            sjsc_pkg::MUL_FSQ:     tmp_r  <= mul_res >>> 1;
            sjsc_pkg::MUL_COS:     tmp_r  <= sjsc_pkg::sat_add(tmp_r, mul_res);
            sjsc_pkg::MUL_SCALE:   core_r <= mul_res;
            sjsc_pkg::MUL_CORE:    core_r <= mul_res;
            sjsc_pkg::MUL_SIN:     tmp_r  <= mul_res;
            sjsc_pkg::MUL_VEL:     vel_r  <= mul_res;
            sjsc_pkg::MUL_APK:     apk_r  <= mul_res;
            sjsc_pkg::MUL_ACC:     acc_r  <= mul_res;
            sjsc_pkg::MUL_APK_INV: tmp_r  <= mul_res;
            sjsc_pkg::MUL_TWO_PI:  tmp_r  <= mul_res;
            sjsc_pkg::MUL_JERK:    jerk_r <= mul_res;
            default: ;
          endcase
        end
      end

      sjsc_pkg::ST_CORDIC: begin
        if (!cor_last) begin
          // rotate toward zero residual angle
          if (z_r[63]) begin
            x_r <= x_r + cor_dx;
            y_r <= y_r - cor_dy;
            z_r <= z_r + $signed(atan_tab[cor_sh]);
          end else begin
            x_r <= x_r - cor_dx;
            y_r <= y_r + cor_dy;
            z_r <= z_r - $signed(atan_tab[cor_sh]);
          end
        end else begin
          // undo the quadrant fold
          case (quad)
            2'd0:    begin c_r <= c0;  s_r <= s0;  end
            2'd1:    begin c_r <= -s0; s_r <= c0;  end
            2'd2:    begin c_r <= -c0; s_r <= -s0; end
            default: begin c_r <= s0;  s_r <= -c0; end
          endcase
        end
      end

      default: ;
    endcase

    // output register
    if (out_load) begin
      position     <= decel ? sjsc_pkg::sat_sub(sjsc_pkg::ONE_Q32, core_r) : core_r;
      velocity     <= vel_r;
      acceleration <= decel ? sjsc_pkg::sat_sub(64'sd0, acc_r) : acc_r;
      jerk_value   <= jerk_r;
    end
  end

endmodule
`default_nettype wire
